FILE: hdl/lsha_pkg.sv
package lsha_pkg;

    localparam int SampleWidth  = 9;
    localparam int PercentWidth = 7;
    localparam int DutyWidth    = 8;
    localparam int DebWidth     = 8;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 8;

    localparam logic signed [SampleWidth-1:0] AngleMin = -9'sd135;
    localparam logic signed [SampleWidth-1:0] AngleMax = 9'sd135;
    localparam logic [SampleWidth-1:0]        AngleHalf = 9'd135;

    // raw = (angle + 135) * 100 / 270 = (x * 10) / 27
    // floor(n / 27) = (n * 2428) >> 16, exact for n <= 2700
    localparam logic [11:0] Div27Mul   = 12'd2428;
    localparam int          Div27Shift = 16;

    // duty = lvl * 255 / 100, floor(n / 100) = (n * 41944) >> 22, exact for n <= 32385
    localparam logic [15:0] Div100Mul   = 16'd41944;
    localparam int          Div100Shift = 22;

    localparam logic [DutyWidth-1:0]    DutyFull    = 8'd255;
    localparam logic [PercentWidth-1:0] ActiveLevel = 7'd10;

    localparam logic [PercentWidth-1:0] ClampLowReset  = 7'd0;
    localparam logic [PercentWidth-1:0] ClampHighReset = 7'd100;
    localparam logic [PercentWidth-1:0] AlertOnReset   = 7'd80;
    localparam logic [PercentWidth-1:0] AlertOffReset  = 7'd70;
    localparam logic [DebWidth-1:0]     DebounceReset  = 8'd3;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_CLAMP_LOW  = 3'd0,
        REG_CLAMP_HIGH = 3'd1,
        REG_ALERT_ON   = 3'd2,
        REG_ALERT_OFF  = 3'd3,
        REG_DEBOUNCE   = 3'd4
    } cfg_reg_t;

endpackage

FILE: hdl/level_scaler_hysteresis_alert.sv
// Angle sample to percent level, PWM duty and a debounced hysteresis alert.
//
// Input channel: sample_valid / sample_stall carry one signed angle_sample per
// request. Output channel: result_valid / result_stall carry raw_level, level,
// pwm_duty, alert and active_led, one result per sample, in order.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 clamp_low, 1 clamp_high, 2 alert_on_level, 3 alert_off_level,
// 4 debounce_count); write only while no sample is in flight.
//
// The first register holds the raw level when a sample is accepted; the second
// holds the clamped result, sets result_valid and updates the alert/debounce
// state when it loads; that waits while a stalled result holds the output.
// One sample is accepted every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; one more sample is
// taken into the first stage, then sample_stall rises until the result moves.
// Reset clears both valid flags, the alert state and the bounce counter, and
// loads the configuration registers with their default values.
module level_scaler_hysteresis_alert
    import lsha_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [CfgIdxWidth-1:0]         cfg_index,
    input  logic [CfgDataWidth-1:0]        cfg_data,

    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SampleWidth-1:0]  angle_sample,

    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [PercentWidth-1:0]        raw_level,
    output logic [PercentWidth-1:0]        level,
    output logic [DutyWidth-1:0]           pwm_duty,
    output logic                           alert,
    output logic                           active_led
);

    logic [PercentWidth-1:0] clamp_low_reg, clamp_high_reg;
    logic [PercentWidth-1:0] alert_on_reg, alert_off_reg;
    logic [DebWidth-1:0]     debounce_reg;

    logic                    s1_valid_reg;
    logic [PercentWidth-1:0] s1_raw_reg;

    logic                    out_valid_reg;
    logic [PercentWidth-1:0] out_raw_reg, out_level_reg;
    logic [DutyWidth-1:0]    out_duty_reg;
    logic                    out_active_reg;

    logic                    committed_reg, committed_next;
    logic                    pending_reg, pending_next;
    logic [DebWidth-1:0]     bounce_reg, bounce_next;

    logic                    s1_load, out_load;

    logic signed [SampleWidth-1:0] angle_sat;
    logic [SampleWidth-1:0]        angle_off;
    logic [11:0]                   raw_num;
    logic [23:0]                   raw_prod;
    logic [PercentWidth-1:0]       raw_calc;

    logic [PercentWidth-1:0] lvl;
    logic [15:0]             duty_num;
    logic [31:0]             duty_prod;
    logic [9:0]              duty_wide;
    logic [DutyWidth-1:0]    duty;
    logic                    desired;
    logic [DebWidth:0]       cnt;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_low_reg  <= ClampLowReset;
            clamp_high_reg <= ClampHighReset;
            alert_on_reg   <= AlertOnReset;
            alert_off_reg  <= AlertOffReset;
            debounce_reg   <= DebounceReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLAMP_LOW:  clamp_low_reg  <= cfg_data[PercentWidth-1:0];
                REG_CLAMP_HIGH: clamp_high_reg <= cfg_data[PercentWidth-1:0];
                REG_ALERT_ON:   alert_on_reg   <= cfg_data[PercentWidth-1:0];
                REG_ALERT_OFF:  alert_off_reg  <= cfg_data[PercentWidth-1:0];
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[DebWidth-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_load     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !out_load;
    assign s1_load      = sample_valid && !sample_stall;

    // ---------------- stage 1: raw level ----------------
    always_comb
    begin
        if (angle_sample < AngleMin)
            angle_sat = AngleMin;
        else if (angle_sample > AngleMax)
            angle_sat = AngleMax;
        else
            angle_sat = angle_sample;
        angle_off = $unsigned(angle_sat) + AngleHalf;
        raw_num   = {angle_off, 3'b000} + {2'b00, angle_off, 1'b0};
        raw_prod  = raw_num * Div27Mul;
        raw_calc  = raw_prod[Div27Shift +: PercentWidth];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (out_load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_raw_reg <= raw_calc;
    end

    // ---------------- stage 2: clamp, duty, alert ----------------
    always_comb
    begin
        priority if (s1_raw_reg < clamp_low_reg)
            lvl = clamp_low_reg;
        else if (s1_raw_reg > clamp_high_reg)
            lvl = clamp_high_reg;
        else
            lvl = s1_raw_reg;

        duty_num  = ({9'd0, lvl} << 8) - {9'd0, lvl};
        duty_prod = duty_num * Div100Mul;
        duty_wide = duty_prod[Div100Shift +: 10];
        duty      = (duty_wide > {2'b00, DutyFull}) ? DutyFull : duty_wide[DutyWidth-1:0];

        priority if (!committed_reg && lvl > alert_on_reg)
            desired = 1'b1;
        else if (committed_reg && lvl < alert_off_reg)
            desired = 1'b0;
        else
            desired = committed_reg;

        if (desired == pending_reg)
        begin
            pending_next = pending_reg;
            cnt          = {1'b0, bounce_reg} + 9'd1;
        end
        else
        begin
            pending_next = desired;
            cnt          = 9'd1;
        end

        if (cnt >= {1'b0, debounce_reg})
        begin
            committed_next = pending_next;
            bounce_next    = debounce_reg;
        end
        else
        begin
            committed_next = committed_reg;
            bounce_next    = cnt[DebWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            committed_reg <= 1'b0;
            pending_reg   <= 1'b0;
            bounce_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                committed_reg <= committed_next;
                pending_reg   <= pending_next;
                bounce_reg    <= bounce_next;
            end
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_raw_reg    <= s1_raw_reg;
            out_level_reg  <= lvl;
            out_duty_reg   <= duty;
            out_active_reg <= (lvl > ActiveLevel);
        end
    end

    assign result_valid = out_valid_reg;
    assign raw_level    = out_raw_reg;
    assign level        = out_level_reg;
    assign pwm_duty     = out_duty_reg;
    assign alert        = committed_reg;
    assign active_led   = out_active_reg;

endmodule
